// ===== hdl/frame_bitmap_allocator_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Frame bitmap allocator assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef FRAME_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define FRAME_BITMAP_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define FBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/fba_pkg.sv =====
// ---------------------------------------------------------------------------
// Frame bitmap allocator package
// Widths, codes and the command/status bundles between control and datapath.
// ---------------------------------------------------------------------------
package fba_pkg;

    localparam int MAX_FRAMES = 64;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int PAGE_W     = 13;
    localparam int WORD_W     = 19;
    localparam int IDX_W      = 7;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int PROD_W     = CNT_W + PAGE_W;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_WORDS    = 1'd1;

    localparam logic [STATUS_W-1:0] ST_ALLOC    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FREE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd4;

    localparam logic [CNT_W-1:0]  RST_FRAMES = CNT_W'(MAX_FRAMES);
    localparam logic [PAGE_W-1:0] RST_PAGE   = 13'd16;

    typedef struct packed {
        logic capture;      // latch the input word
        logic calc;         // register the limit products
        logic emit_single;  // one-result outcome of an allocate
        logic scan_init;    // start the map scan
        logic claim;        // take the frame at the scan pointer
        logic skip;         // step past an occupied frame
        logic free_frame;   // perform a release word
    } t_cmd;

    typedef struct packed {
        logic op;
        logic too_big;
        logic zero_req;
        logic no_free;
        logic cur_free;
        logic claim_last;
        logic out_free;
    } t_sts;

endpackage

// ===== hdl/fba_ctrl.sv =====
// ---------------------------------------------------------------------------
// Frame bitmap allocator controller
// Sequences capture, limit check, the first-fit map scan and releases.
// ---------------------------------------------------------------------------
`include "frame_bitmap_allocator_unit_macros.svh"

module fba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  fba_pkg::t_sts  i_sts,
    output fba_pkg::t_cmd  o_cmd
);
    import fba_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CALC   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_SCAN   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.op == OP_RELEASE) begin
                    if (i_sts.out_free) begin
                        o_cmd.free_frame = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else if (i_sts.too_big || i_sts.zero_req || i_sts.no_free) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit_single = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_sts.cur_free) begin
                    o_cmd.skip = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.claim = 1'b1;
                    if (i_sts.claim_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `FBA_ASSERT_NOW(a_cmd_excl, 1'b1, $onehot0({o_cmd.emit_single, o_cmd.claim, o_cmd.skip, o_cmd.free_frame, o_cmd.scan_init}), "more than one datapath action")
    `FBA_ASSERT_NOW(a_scan_alloc, r_state == S_SCAN, i_sts.op == OP_ALLOC, "scan running for a release word")
    `FBA_ASSERT_NOW(a_calc_after_accept, r_state == S_CALC, $past(r_state) == S_IDLE && $past(i_valid), "limit check without an accepted word")

endmodule

// ===== hdl/fba_datapath.sv =====
// ---------------------------------------------------------------------------
// Frame bitmap allocator datapath
// Config registers, free map and count, limit products, scan pointer and
// the output register.
// ---------------------------------------------------------------------------
`include "frame_bitmap_allocator_unit_macros.svh"

module fba_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wen,
    input  logic [fba_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fba_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              i_op,
    input  logic [fba_pkg::WORD_W-1:0]        i_word_count,
    input  logic [fba_pkg::IDX_W-1:0]         i_frame_index,
    input  logic                              i_end_of_list,
    input  fba_pkg::t_cmd                     i_cmd,
    output fba_pkg::t_sts                     o_sts,
    input  logic                              i_ready,
    output logic                              o_valid,
    output logic [fba_pkg::FRAME_W-1:0]       o_frame,
    output logic                              o_frame_valid,
    output logic [fba_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_last,
    output logic                              o_list_done
);
    import fba_pkg::*;

    logic [CNT_W-1:0]      r_frames_in_use;
    logic [PAGE_W-1:0]     r_page_words;
    logic [MAX_FRAMES-1:0] r_free_map;
    logic [CNT_W-1:0]      r_free_count;

    logic                  r_op;
    logic [WORD_W-1:0]     r_words;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_eol;
    logic [PROD_W-1:0]     r_lim_all;
    logic [PROD_W-1:0]     r_lim_free;
    logic [FRAME_W-1:0]    r_scan;
    logic [WORD_W-1:0]     r_remaining;

    logic                  r_o_valid;
    logic [FRAME_W-1:0]    r_o_frame;
    logic                  r_o_frame_valid;
    logic [STATUS_W-1:0]   r_o_status;
    logic                  r_o_last;
    logic                  r_o_list_done;

    logic [CNT_W-1:0]      w_n_eff;
    logic [PAGE_W-1:0]     w_pw_eff;
    logic [CNT_W-1:0]      w_cfg_n;
    logic                  w_in_range;
    logic                  w_rel_was_busy;
    logic                  w_load;
    logic [STATUS_W-1:0]   w_single_status;
    logic [MAX_FRAMES-1:0] w_mask;

    assign w_n_eff  = (r_frames_in_use > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES)
                                                             : r_frames_in_use;
    assign w_pw_eff = (r_page_words == '0) ? PAGE_W'(1) : r_page_words;
    assign w_cfg_n  = (i_cfg_wdata[CNT_W-1:0] > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES)
                                                                     : i_cfg_wdata[CNT_W-1:0];

    assign w_in_range     = (r_idx < IDX_W'(w_n_eff));
    assign w_rel_was_busy = !r_free_map[r_idx[FRAME_W-1:0]];

    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            w_mask[i] = (CNT_W'(i) < w_n_eff);
        end
    end

    // need > free frames is the same as words > free * page
    assign o_sts.op         = r_op;
    assign o_sts.too_big    = (PROD_W'(r_words) > r_lim_all);
    assign o_sts.zero_req   = (r_words == '0);
    assign o_sts.no_free    = (PROD_W'(r_words) > r_lim_free);
    assign o_sts.cur_free   = r_free_map[r_scan];
    assign o_sts.claim_last = (r_remaining <= WORD_W'(w_pw_eff));
    assign o_sts.out_free   = !r_o_valid || i_ready;

    assign w_single_status = o_sts.too_big  ? ST_TOO_BIG :
                             o_sts.zero_req ? ST_ALLOC   : ST_NO_FREE;

    assign w_load = i_cmd.emit_single || i_cmd.claim || i_cmd.free_frame;

    // config and map state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= RST_FRAMES;
            r_page_words    <= RST_PAGE;
            r_free_map      <= '1;
            r_free_count    <= RST_FRAMES;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                REG_FRAMES_IN_USE: begin
                    r_frames_in_use <= i_cfg_wdata[CNT_W-1:0];
                    r_free_map      <= '1;
                    r_free_count    <= w_cfg_n;
                end
                REG_PAGE_WORDS: begin
                    r_page_words <= i_cfg_wdata[PAGE_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (i_cmd.claim) begin
            r_free_map[r_scan] <= 1'b0;
            r_free_count       <= r_free_count - CNT_W'(1);
        end else if (i_cmd.free_frame && w_in_range) begin
            r_free_map[r_idx[FRAME_W-1:0]] <= 1'b1;
            if (w_rel_was_busy) begin
                r_free_count <= r_free_count + CNT_W'(1);
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_words <= i_word_count;
            r_idx   <= i_frame_index;
            r_eol   <= i_end_of_list;
        end
        if (i_cmd.calc) begin
            r_lim_all  <= PROD_W'(w_n_eff) * PROD_W'(w_pw_eff);
            r_lim_free <= PROD_W'(r_free_count) * PROD_W'(w_pw_eff);
        end
        if (i_cmd.scan_init) begin
            r_scan      <= '0;
            r_remaining <= r_words;
        end else if (i_cmd.claim || i_cmd.skip) begin
            r_scan <= r_scan + FRAME_W'(1);
            if (i_cmd.claim) begin
                r_remaining <= r_remaining - WORD_W'(w_pw_eff);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_single) begin
            r_o_frame       <= '0;
            r_o_frame_valid <= 1'b0;
            r_o_status      <= w_single_status;
            r_o_last        <= 1'b1;
            r_o_list_done   <= 1'b0;
        end else if (i_cmd.claim) begin
            r_o_frame       <= r_scan;
            r_o_frame_valid <= 1'b1;
            r_o_status      <= ST_ALLOC;
            r_o_last        <= o_sts.claim_last;
            r_o_list_done   <= 1'b0;
        end else if (i_cmd.free_frame) begin
            r_o_frame       <= w_in_range ? r_idx[FRAME_W-1:0] : '0;
            r_o_frame_valid <= w_in_range;
            r_o_status      <= w_in_range ? ST_RELEASED : ST_IGNORED;
            r_o_last        <= 1'b1;
            r_o_list_done   <= r_eol;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_frame       = r_o_frame;
    assign o_frame_valid = r_o_frame_valid;
    assign o_status      = r_o_status;
    assign o_last        = r_o_last;
    assign o_list_done   = r_o_list_done;

    `FBA_ASSERT_NOW(a_count_matches_map, 1'b1, $countones(r_free_map & w_mask) == int'(r_free_count), "free count differs from map")
    `FBA_ASSERT_NOW(a_count_bound, 1'b1, r_free_count <= w_n_eff, "free count above frame count")
    `FBA_ASSERT_NEXT(a_claim_clears, i_cmd.claim, !r_free_map[$past(r_scan)], "claimed frame still free")

endmodule

// ===== hdl/frame_bitmap_allocator_unit.sv =====
// Allocate: limit check in the calc and decide states, then one map entry per
//   cycle from frame 0 until the last needed frame is taken; a claim waits
//   for a free output. Failed, zero-word and release words end in decide.
// One result word per cycle, i_ready permitting, from a registered output stage.
// Synchronous active-low reset: all frames free, 64 frames, 16 words per page.
// ---------------------------------------------------------------------------
// Frame bitmap allocator
// First-fit page-frame allocator over a free bitmap.
// ---------------------------------------------------------------------------
module frame_bitmap_allocator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wen,
    input  logic [fba_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fba_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_op,
    input  logic [fba_pkg::WORD_W-1:0]        i_word_count,
    input  logic [fba_pkg::IDX_W-1:0]         i_frame_index,
    input  logic                              i_end_of_list,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [fba_pkg::FRAME_W-1:0]       o_frame,
    output logic                              o_frame_valid,
    output logic [fba_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_last,
    output logic                              o_list_done
);
    import fba_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    fba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    fba_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_op          (i_op),
        .i_word_count  (i_word_count),
        .i_frame_index (i_frame_index),
        .i_end_of_list (i_end_of_list),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_frame       (o_frame),
        .o_frame_valid (o_frame_valid),
        .o_status      (o_status),
        .o_last        (o_last),
        .o_list_done   (o_list_done)
    );

endmodule
